FILE: rtl/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and byte constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    // command codes on the input word
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // byte boundaries and masks
    localparam logic [7:0] ASCII_MAX   = 8'h7f;
    localparam logic [7:0] BAD_C0      = 8'hc0;
    localparam logic [7:0] BAD_C1      = 8'hc1;
    localparam logic [7:0] BAD_MIN     = 8'hf5;
    localparam logic [7:0] CONT_MASK   = 8'hc0;
    localparam logic [7:0] CONT_MATCH  = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'he0;
    localparam logic [7:0] LEAD2_MATCH = 8'hc0;
    localparam logic [7:0] LEAD3_MASK  = 8'hf0;
    localparam logic [7:0] LEAD3_MATCH = 8'he0;

    typedef logic [1:0] cont_cnt_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic      valid_so_far;
        logic      string_done;
        cont_cnt_t pending_continuations;
    } out_word_t;

    // classification of one data byte
    typedef struct packed {
        logic      is_ascii;
        logic      is_bad;
        logic      is_cont;
        cont_cnt_t lead_cont;
    } byte_class_t;

endpackage

FILE: rtl/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// UTF-8 well-formedness checker for a byte stream, one string at a time.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one word per byte (command = data) or an end-of-string
//   marker (command = end). m_ channel returns exactly one result word for
//   every input word, in order.
//   An input word is registered on acceptance; from the input register it is
//   checked against the continuation counter and the result is registered in
//   the result register, which drives m_valid. Throughput is one word per
//   cycle while m_ready stays high; the counter update is a short compare
//   and decrement between the input and result registers.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_ready drops only when both are occupied and m_ready
//   is low. On reset both registers are empty, the counter is zero and the
//   error flag is clear. The end-of-string word gives the verdict and
//   clears the state for the next string.
// ----------------------------------------------------------------------------
module utf8_stream_validator
    import utf8v_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic        in_vld_reg;
    in_word_t    in_word_reg;
    logic        out_vld_reg;
    out_word_t   out_word_reg;
    logic        out_free;
    logic        advance;
    byte_class_t byte_class;
    out_word_t   result;

    assign out_free = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;
    assign m_valid  = out_vld_reg;
    assign m_data   = out_word_reg;

    utf8v_byte_class u_class (
        .data_byte  (in_word_reg.data_byte),
        .byte_class (byte_class)
    );

    utf8v_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .command    (in_word_reg.command),
        .byte_class (byte_class),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_free) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= result;
        end
    end

endmodule

FILE: rtl/utf8v_byte_class.sv
// ----------------------------------------------------------------------------
// utf8v_byte_class
// Sorts one byte into ascii, forbidden, continuation or lead with its length.
// ----------------------------------------------------------------------------
module utf8v_byte_class
    import utf8v_pkg::*;
(
    input  logic [7:0]  data_byte,
    output byte_class_t byte_class
);

    always_comb begin
        byte_class.is_ascii = (data_byte <= ASCII_MAX);
        byte_class.is_bad   = (data_byte == BAD_C0) || (data_byte == BAD_C1) ||
                              (data_byte >= BAD_MIN);
        byte_class.is_cont  = ((data_byte & CONT_MASK) == CONT_MATCH);
        // continuations owed after a lead byte
        if ((data_byte & LEAD2_MASK) == LEAD2_MATCH) begin
            byte_class.lead_cont = 2'd1;
        end else if ((data_byte & LEAD3_MASK) == LEAD3_MATCH) begin
            byte_class.lead_cont = 2'd2;
        end else begin
            byte_class.lead_cont = 2'd3;
        end
    end

endmodule

FILE: rtl/utf8v_checker.sv
// ----------------------------------------------------------------------------
// utf8v_checker
// Continuation counter and sticky error flag; forms the result word.
// ----------------------------------------------------------------------------
module utf8v_checker
    import utf8v_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        command,
    input  byte_class_t byte_class,
    output out_word_t   result
);

    cont_cnt_t cnt_reg, cnt_next;
    logic      err_reg, err_next;

    always_comb begin
        cnt_next = cnt_reg;
        err_next = err_reg;
        if (command == CMD_END) begin
            cnt_next = 2'd0;
            err_next = 1'b0;
        end else if (!err_reg) begin
            if (byte_class.is_ascii) begin
                err_next = (cnt_reg != 2'd0);
            end else if (byte_class.is_bad) begin
                err_next = 1'b1;
            end else if (byte_class.is_cont) begin
                if (cnt_reg == 2'd0) begin
                    err_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg - 2'd1;
                end
            end else if (cnt_reg != 2'd0) begin
                err_next = 1'b1;
            end else begin
                cnt_next = byte_class.lead_cont;
            end
            if (err_next) begin
                cnt_next = 2'd0;
            end
        end
    end

    always_comb begin
        if (command == CMD_END) begin
            result.valid_so_far          = !err_reg;
            result.string_done           = 1'b1;
            result.pending_continuations = 2'd0;
        end else begin
            result.valid_so_far          = !err_next;
            result.string_done           = 1'b0;
            result.pending_continuations = cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            err_reg <= 1'b0;
        end else if (advance) begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    a_err_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> (cnt_reg == 2'd0))
        else $error("count left nonzero after an error");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && command == CMD_END) |=> (!err_reg && cnt_reg == 2'd0))
        else $error("end of string did not clear the state");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && command == CMD_DATA && err_reg) |=> err_reg)
        else $error("error flag dropped inside a string");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(cnt_reg) && $stable(err_reg)))
        else $error("state moved without a word");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_stream_validator: directed strings cover every
// byte class and error case, then random strings, mostly well-formed, with
// some truncated or corrupted. Every result word is checked in order against
// a behavioral UTF-8 state tracker, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import utf8v_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    utf8_stream_validator i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    in_word_t  pending_words[$];
    out_word_t expected_verdicts[$];

    // tracker state for the string in flight
    cont_cnt_t owed_cont = '0;
    logic      bad_seen  = 1'b0;

    logic word_taken   = 1'b0;
    int   words_in     = 0;
    int   results_seen = 0;
    int   mismatches   = 0;
    int   send_gap     = 0;
    int   gap_roll;
    int   hold_left    = 0;
    int   ready_roll;
    logic choke_done   = 1'b0;
    logic quiet_phase;

    // stretches where neither side idles
    assign quiet_phase = ((words_in / 64) % 4) == 2;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic out_word_t track_utf8(in_word_t w);
        out_word_t  res;
        logic [7:0] b;
        logic       bad;
        b   = w.data_byte;
        bad = 1'b0;
        if (w.command == CMD_END) begin
            res.valid_so_far          = !bad_seen;
            res.string_done           = 1'b1;
            res.pending_continuations = '0;
            bad_seen  = 1'b0;
            owed_cont = '0;
            return res;
        end
        // bytes after an error are ignored
        if (!bad_seen) begin
            if (b <= ASCII_MAX) begin
                bad = (owed_cont != 0);
            end else if (b == BAD_C0 || b == BAD_C1 || b >= BAD_MIN) begin
                bad = 1'b1;
            end else if ((b & CONT_MASK) == CONT_MATCH) begin
                if (owed_cont == 0) bad = 1'b1;
                else owed_cont = owed_cont - 2'd1;
            end else if (owed_cont != 0) begin
                bad = 1'b1;
            end else if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
                owed_cont = 2'd1;
            end else if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
                owed_cont = 2'd2;
            end else begin
                owed_cont = 2'd3;
            end
            if (bad) begin
                bad_seen  = 1'b1;
                owed_cont = '0;
            end
        end
        res.valid_so_far          = !bad_seen;
        res.string_done           = 1'b0;
        res.pending_continuations = owed_cont;
        return res;
    endfunction

    task automatic queue_byte(logic [7:0] b);
        in_word_t w;
        w.command   = CMD_DATA;
        w.data_byte = b;
        pending_words = {pending_words, w};
    endtask

    task automatic queue_end();
        in_word_t w;
        w.command   = CMD_END;
        w.data_byte = 8'($urandom_range(0, 255));
        pending_words = {pending_words, w};
    endtask

    // driver: words change on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                s_valid <= 1'b1;
                s_data  <= pending_words.pop_front();
                gap_roll = $urandom_range(0, 99);
                if (quiet_phase || gap_roll < 60) send_gap = 0;
                else if (gap_roll < 92) send_gap = $urandom_range(1, 3);
                else send_gap = $urandom_range(8, 30);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver readiness, with one long hold-off to back up the input
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!choke_done && results_seen >= 120) begin
            choke_done = 1'b1;
            hold_left  = 80;
            m_ready <= 1'b0;
        end else if (quiet_phase) begin
            m_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                hold_left = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 20);
            end
        end
    end

    // accepted input words feed the tracker
    always @(posedge aclk) begin
        word_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_verdicts = {expected_verdicts, track_utf8(s_data)};
            words_in++;
        end
    end

    // result checker
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: expected no result, got valid=%0b done=%0b pend=%0d",
                         $time, m_data.valid_so_far, m_data.string_done,
                         m_data.pending_continuations);
            end else begin
                want = expected_verdicts.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    $display("%0t: result %0d expected valid=%0b done=%0b pend=%0d,",
                             $time, results_seen, want.valid_so_far, want.string_done,
                             want.pending_continuations);
                    $display("%0t: result %0d got valid=%0b done=%0b pend=%0d",
                             $time, results_seen, m_data.valid_so_far,
                             m_data.string_done, m_data.pending_continuations);
                end
            end
        end
    end

    initial begin
        logic [7:0] str_bytes[$];
        int         items;
        int         n_cp;
        int         kind;
        int         roll;

        // empty string
        queue_end();
        // ascii extremes, two-byte extremes
        queue_byte(8'h00); queue_byte(8'h7f);
        queue_byte(8'hc2); queue_byte(8'h80);
        queue_byte(8'hdf); queue_byte(8'hbf);
        queue_end();
        // three- and four-byte leads at their ends
        queue_byte(8'he0); queue_byte(8'h80); queue_byte(8'h80);
        queue_byte(8'hf4); queue_byte(8'hbf); queue_byte(8'hbf); queue_byte(8'hbf);
        queue_end();
        // cut short at the end still passes
        queue_byte(8'hf0); queue_byte(8'h90);
        queue_end();
        // overlong lead, then a byte after the error
        queue_byte(8'hc0); queue_byte(8'h41);
        queue_end();
        // stray continuation
        queue_byte(8'h80);
        queue_end();
        // ascii while a continuation is owed
        queue_byte(8'hef); queue_byte(8'h41);
        queue_end();
        // lead while a continuation is owed
        queue_byte(8'hc2); queue_byte(8'hc3);
        queue_end();
        // out-of-range leads
        queue_byte(8'hc1); queue_byte(8'hf5); queue_byte(8'hff);
        queue_end();

        items = 0;
        while (items < 450) begin
            str_bytes.delete();
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                // noise
                n_cp = $urandom_range(1, 6);
                repeat (n_cp) str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
            end else begin
                n_cp = $urandom_range(0, 6);
                repeat (n_cp) begin
                    kind = $urandom_range(0, 3);
                    case (kind)
                        0: begin
                            str_bytes = {str_bytes, 8'($urandom_range(8'h00, 8'h7f))};
                        end
                        1: begin
                            str_bytes = {str_bytes, 8'($urandom_range(8'hc2, 8'hdf))};
                        end
                        2: begin
                            str_bytes = {str_bytes, 8'($urandom_range(8'he0, 8'hef))};
                        end
                        default: begin
                            str_bytes = {str_bytes, 8'($urandom_range(8'hf0, 8'hf4))};
                        end
                    endcase
                    repeat (kind) str_bytes = {str_bytes, 8'($urandom_range(8'h80, 8'hbf))};
                end
                if (roll < 20 && str_bytes.size() != 0) begin
                    // truncate the tail
                    str_bytes.delete(str_bytes.size() - 1);
                end else if (roll < 32 && str_bytes.size() != 0) begin
                    // corrupt one byte
                    str_bytes[$urandom_range(0, str_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
                end else if (roll < 40) begin
                    // insert a stray byte
                    str_bytes.insert($urandom_range(0, str_bytes.size()),
                                     8'($urandom_range(0, 255)));
                end
            end
            foreach (str_bytes[k]) queue_byte(str_bytes[k]);
            queue_end();
            items += str_bytes.size() + 1;
        end

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        while (pending_words.size() != 0 || s_valid) @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("utf8_stream_validator: match");
        end else begin
            $display("utf8_stream_validator: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("utf8_stream_validator: mismatch");
        $finish;
    end

endmodule
